@@ rtl/tea_16bit_block_cipher_assert.svh @@
// Assertion macros used by the round stage RTL. They compile to nothing under synthesis.
`ifndef TEA_16BIT_BLOCK_CIPHER_ASSERT_SVH
`define TEA_16BIT_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS
`define TEA16_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TEA16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TEA16_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TEA16_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/tea16_pkg.sv @@
package tea16_pkg;

	localparam int unsigned WordW  = 16;
	localparam int unsigned Rounds = 32;
	localparam int unsigned Delta  = 32'h0000_9e37;

	typedef logic [WordW-1:0] word_t;

	typedef enum logic {
		FUNC_ENCRYPT = 1'b0,
		FUNC_DECRYPT = 1'b1
	} func_t;

	typedef struct packed {
		func_t func;
		word_t y;
		word_t z;
		word_t ka;
		word_t kb;
	} data_t;

	function automatic word_t round_sum(input int unsigned r);
		int unsigned prod;
		prod = Delta * r;
		return prod[WordW-1:0];
	endfunction

	function automatic word_t tea_mix(input word_t x, input word_t s, input word_t ka,
			input word_t kb);
		word_t a;
		word_t b;
		word_t c;
		a = {x[WordW-3:0], 2'b00} + ka;
		b = x + s;
		c = {3'b000, x[WordW-1:3]} + kb;
		return a ^ b ^ c;
	endfunction

endpackage

@@ rtl/tea16_item_if.sv @@
interface tea16_item_if import tea16_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  func;
	word_t word_y;
	word_t word_z;
	word_t key_a;
	word_t key_b;

	modport source (output valid, output func, output word_y, output word_z,
		output key_a, output key_b, input ready);
	modport sink (input valid, input func, input word_y, input word_z,
		input key_a, input key_b, output ready);
endinterface

@@ rtl/tea16_result_if.sv @@
interface tea16_result_if import tea16_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t out_y;
	word_t out_z;

	modport source (output valid, output out_y, output out_z, input ready);
	modport sink (input valid, input out_y, input out_z, output ready);
endinterface

@@ rtl/tea16_round.sv @@
`include "tea_16bit_block_cipher_assert.svh"

module tea16_round import tea16_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  word_t sum_enc,
	input  word_t sum_dec,
	input  logic  prev_valid,
	output logic  prev_ready,
	input  data_t prev_data,
	output logic  next_valid,
	input  logic  next_ready,
	output data_t next_data
);

	logic  valid_s1;
	data_t data_s1;
	data_t round_d;
	word_t enc_y;
	word_t enc_z;
	word_t dec_y;
	word_t dec_z;

	// A stage takes a new transaction when it is empty or its content moves on.
	assign prev_ready = !valid_s1 || next_ready;

	always_comb begin
		enc_y = prev_data.y + tea_mix(prev_data.z, sum_enc, prev_data.ka, prev_data.kb);
		enc_z = prev_data.z + tea_mix(enc_y, sum_enc, prev_data.ka, prev_data.kb);
		dec_z = prev_data.z - tea_mix(prev_data.y, sum_dec, prev_data.ka, prev_data.kb);
		dec_y = prev_data.y - tea_mix(dec_z, sum_dec, prev_data.ka, prev_data.kb);
		round_d = prev_data;
		case (prev_data.func)
			FUNC_ENCRYPT: begin
				round_d.y = enc_y;
				round_d.z = enc_z;
			end
			FUNC_DECRYPT: begin
				round_d.y = dec_y;
				round_d.z = dec_z;
			end
			default: begin
				round_d.y = enc_y;
				round_d.z = enc_z;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (prev_ready) begin
			valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready && prev_valid) begin
			data_s1 <= round_d;
		end
	end

	assign next_valid = valid_s1;
	assign next_data  = data_s1;

	`TEA16_ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1 && !next_ready, valid_s1 && $stable(data_s1))
	`TEA16_ASSERT_NEXT(a_accept_fills, clk, arst_n, prev_valid && prev_ready, valid_s1)
	`TEA16_ASSERT_NOW(a_empty_ready, clk, arst_n, !valid_s1, prev_ready)

endmodule

@@ rtl/tea_16bit_block_cipher.sv @@
// Reduced TEA cipher on a 32-bit block of two 16-bit halves with two 16-bit key words.
// The item channel carries func (0 encrypt, 1 decrypt), word_y, word_z, key_a and key_b;
// the result channel returns out_y and out_z. Both use valid/ready, and a transaction
// completes at a rising edge where valid and ready are both high.
// The cipher is fully unrolled: one pipeline stage per round, each stage holding a
// register and a valid bit. With an attentive receiver one transaction is taken and
// one delivered every cycle.
// The last round's register drives the result channel directly.
// When the receiver stalls, each full stage holds its content; ready propagates back
// stage by stage, so empty stages keep filling and the item channel stays ready until
// every stage is occupied. Nothing is lost or repeated across a stall.
// Results come out in the order the items went in.
// Reset (arst_n low, asynchronous) clears all valid bits, so the pipeline is empty and
// the item channel is ready at once afterwards. The data registers are not reset.

module tea_16bit_block_cipher import tea16_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	tea16_item_if.sink     item,
	tea16_result_if.source result
);

	logic  valid_chain [0:Rounds];
	logic  ready_chain [0:Rounds];
	data_t data_chain  [0:Rounds];

	assign valid_chain[0]   = item.valid;
	assign item.ready       = ready_chain[0];
	assign data_chain[0].func = func_t'(item.func);
	assign data_chain[0].y  = item.word_y;
	assign data_chain[0].z  = item.word_z;
	assign data_chain[0].ka = item.key_a;
	assign data_chain[0].kb = item.key_b;

	for (genvar i = 0; i < Rounds; i++) begin : g_round
		tea16_round u_round (
			.clk        (clk),
			.arst_n     (arst_n),
			.sum_enc    (round_sum(i + 1)),
			.sum_dec    (round_sum(Rounds - i)),
			.prev_valid (valid_chain[i]),
			.prev_ready (ready_chain[i]),
			.prev_data  (data_chain[i]),
			.next_valid (valid_chain[i+1]),
			.next_ready (ready_chain[i+1]),
			.next_data  (data_chain[i+1])
		);
	end

	assign result.valid       = valid_chain[Rounds];
	assign ready_chain[Rounds] = result.ready;
	assign result.out_y       = data_chain[Rounds].y;
	assign result.out_z       = data_chain[Rounds].z;

endmodule
